// ===== design/assert_macros.svh =====
// Assertion macros shared by the rasteriser modules.
// No dependencies; included by the controller and the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ALR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must be followed by a consequence in the next cycle.
`define ALR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/alr_pkg.sv =====
// Types and constants of the antialiased line rasteriser.
// No dependencies; used by the controller, the datapath and the top level.
package alr_pkg;

    localparam int IN_COORD_W = 12;
    localparam int PIX_W      = 14;
    localparam int INTENS_W   = 8;

    localparam logic [INTENS_W-1:0] FULL_INTENSITY = 8'd255;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_MAIN
    } alr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_line;
        logic div_step;
        logic emit_first;
        logic emit_main;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic line_active;
        logic straight_mode;
        logic begin_straight;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/antialiased_line_rasterizer.sv =====
// Top level of the antialiased line rasteriser: controller plus datapath.
// Depends on alr_pkg, alr_controller and alr_datapath.
//
// The input channel (in_valid/in_ready) carries commands. A begin transaction loads two
// endpoints and yields no pixels; a step transaction yields the pixels of one position
// along the major axis on the output channel (out_valid/out_ready).
// Axis-aligned lines give one full-intensity pixel per step. Sloped lines give a pair:
// the neighbour pixel with intensity 255-c first, then the main pixel with intensity c,
// where c is the integer part of a running coverage error.
// A step's first pixel is shown the cycle after it is accepted; the main pixel of a pair
// follows from the main state once the output register is free. A sloped line takes no
// new step until the main pixel of its pair has gone into the single output register.
// A begin for a sloped line holds off the next transaction until the restoring slope
// divider has produced all FRAC_BITS + 8 quotient bits, one quotient bit per cycle.
// A begin for an axis-aligned line skips the divider. Steps on an idle block are dropped.
// When the receiver stalls, the pending pixel holds in the output register and no new
// transaction is taken until it can be replaced. Reset leaves the block idle with no
// line active and the output channel empty.
module antialiased_line_rasterizer
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic [alr_pkg::IN_COORD_W-1:0]       start_x,
    input  logic [alr_pkg::IN_COORD_W-1:0]       start_y,
    input  logic [alr_pkg::IN_COORD_W-1:0]       end_x,
    input  logic [alr_pkg::IN_COORD_W-1:0]       end_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [alr_pkg::PIX_W-1:0]     pixel_x,
    output logic signed [alr_pkg::PIX_W-1:0]     pixel_y,
    output logic [alr_pkg::INTENS_W-1:0]         intensity,
    output logic                                 run_last,
    output logic                                 line_last
);

    // The controller decides what happens each cycle; the datapath holds all line state.
    alr_pkg::dp_cmd_t  dp_cmd;
    alr_pkg::dp_stat_t dp_stat;

    alr_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    alr_datapath
    #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .intensity (intensity),
        .run_last  (run_last),
        .line_last (line_last)
    );

endmodule

// ===== design/alr_controller.sv =====
// Sequencing state machine of the antialiased line rasteriser.
// Depends on alr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module alr_controller
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              command,
    output logic              in_ready,
    input  alr_pkg::dp_stat_t stat,
    output alr_pkg::dp_cmd_t  cmd
);

    alr_pkg::alr_state_t state_reg;
    alr_pkg::alr_state_t state_next;
    logic                accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign accept = in_valid && in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == alr_pkg::CMD_BEGIN)
                    begin
                        if (!stat.begin_straight)
                        begin
                            state_next = alr_pkg::ST_DIVIDE;
                        end
                    end
                    else if (stat.line_active && !stat.straight_mode)
                    begin
                        state_next = alr_pkg::ST_MAIN;
                    end
                end
            end
            alr_pkg::ST_DIVIDE:
            begin
                if (stat.div_done)
                begin
                    state_next = alr_pkg::ST_IDLE;
                end
            end
            alr_pkg::ST_MAIN:
            begin
                if (stat.out_free)
                begin
                    state_next = alr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = alr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready       = 1'b0;
        cmd.load_line  = 1'b0;
        cmd.div_step   = 1'b0;
        cmd.emit_first = 1'b0;
        cmd.emit_main  = 1'b0;
        case (state_reg)
            alr_pkg::ST_IDLE:
            begin
                in_ready       = stat.out_free;
                cmd.load_line  = in_valid && stat.out_free && (command == alr_pkg::CMD_BEGIN);
                cmd.emit_first = in_valid && stat.out_free && (command == alr_pkg::CMD_STEP)
                                 && stat.line_active;
            end
            alr_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            alr_pkg::ST_MAIN:
            begin
                cmd.emit_main = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    `ALR_ASSERT(cmd_exclusive, clk, rst_n, $onehot0({cmd.load_line, cmd.div_step, cmd.emit_first, cmd.emit_main}), "More than one datapath command at once")
    `ALR_ASSERT_NEXT(pair_enters_main, clk, rst_n, cmd.emit_first && !stat.straight_mode, state_reg == alr_pkg::ST_MAIN, "Neighbour pixel not followed by main pixel state")
    `ALR_ASSERT_NEXT(divide_returns_idle, clk, rst_n, state_reg == alr_pkg::ST_DIVIDE && stat.div_done, state_reg == alr_pkg::ST_IDLE, "Division end did not return to idle")

endmodule

// ===== design/alr_datapath.sv =====
// Line state, slope divider and output register of the antialiased line rasteriser.
// Depends on alr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module alr_datapath
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  alr_pkg::dp_cmd_t                     cmd,
    output alr_pkg::dp_stat_t                    stat,
    input  logic [alr_pkg::IN_COORD_W-1:0]       start_x,
    input  logic [alr_pkg::IN_COORD_W-1:0]       start_y,
    input  logic [alr_pkg::IN_COORD_W-1:0]       end_x,
    input  logic [alr_pkg::IN_COORD_W-1:0]       end_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [alr_pkg::PIX_W-1:0]     pixel_x,
    output logic signed [alr_pkg::PIX_W-1:0]     pixel_y,
    output logic [alr_pkg::INTENS_W-1:0]         intensity,
    output logic                                 run_last,
    output logic                                 line_last
);

    localparam int CB        = COORD_BITS;
    localparam int ERR_W     = FRAC_BITS + 8;
    localparam int STEP_W    = FRAC_BITS + 9;
    localparam int DIV_ITERS = FRAC_BITS + 8;
    localparam int CNT_W     = $clog2(DIV_ITERS + 1);
    localparam int IW        = alr_pkg::IN_COORD_W;
    localparam int PW        = alr_pkg::PIX_W;
    localparam int NW        = alr_pkg::INTENS_W;

    // Line state.
    logic              line_active_reg, line_active_next;
    logic              straight_reg, straight_next;
    logic              major_x_reg, major_x_next;
    logic              minor_neg_reg, minor_neg_next;
    logic [CB-1:0]     cur_x_reg, cur_x_next;
    logic [CB-1:0]     cur_y_reg, cur_y_next;
    logic [CB:0]       steps_reg, steps_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [STEP_W-1:0] err_step_reg, err_step_next;

    // Divider.
    logic [CB-1:0]     major_reg, major_next;
    logic [CB-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [PW-1:0]     px_reg, px_next;
    logic [PW-1:0]     py_reg, py_next;
    logic [NW-1:0]     inten_reg, inten_next;
    logic              run_last_reg, run_last_next;
    logic              line_last_reg, line_last_next;

    // Endpoint decoding.
    logic [CB+IW-1:0]  sx_ext, sy_ext, ex_ext, ey_ext;
    logic [CB-1:0]     x1, y1, x2, y2;
    logic              x_lt, y_lt, x_eq, y_eq;
    logic [CB-1:0]     adx, ady, lx, ly, hx, hy;
    logic              b_major_x, b_neg;
    logic [CB-1:0]     b_cx, b_cy, b_major, b_minor;
    logic              b_top;

    // Step arithmetic.
    logic [CB:0]       rem2;
    logic              rem_ge;
    logic [CB:0]       rem_sub;
    logic [CB+PW-1:0]  cx_ext, cy_ext;
    logic [PW-1:0]     cx14, cy14, off14, nx14, ny14;
    logic [NW-1:0]     cov;
    logic              last_step;
    logic [STEP_W-1:0] err_diff;
    logic              err_borrow;
    logic [CB:0]       steps_dec;
    logic              advance;
    logic              out_free;

    assign sx_ext = {{CB{1'b0}}, start_x};
    assign sy_ext = {{CB{1'b0}}, start_y};
    assign ex_ext = {{CB{1'b0}}, end_x};
    assign ey_ext = {{CB{1'b0}}, end_y};
    assign x1 = sx_ext[CB-1:0];
    assign y1 = sy_ext[CB-1:0];
    assign x2 = ex_ext[CB-1:0];
    assign y2 = ey_ext[CB-1:0];

    assign x_lt = x1 < x2;
    assign y_lt = y1 < y2;
    assign x_eq = x1 == x2;
    assign y_eq = y1 == y2;
    assign adx  = x_lt ? (x2 - x1) : (x1 - x2);
    assign ady  = y_lt ? (y2 - y1) : (y1 - y2);
    assign lx   = x_lt ? x1 : x2;
    assign hx   = x_lt ? x2 : x1;
    assign ly   = x_lt ? y1 : y2;
    assign hy   = x_lt ? y2 : y1;

    // Orientation and start point of a new line; vertical wins when both axes match.
    always_comb
    begin
        b_major_x = 1'b0;
        b_neg     = 1'b0;
        b_cx      = x1;
        b_cy      = y_lt ? y1 : y2;
        b_major   = ady;
        b_minor   = '0;
        if (x_eq)
        begin
            b_major_x = 1'b0;
        end
        else if (y_eq)
        begin
            b_major_x = 1'b1;
            b_cx      = lx;
            b_cy      = y1;
            b_major   = adx;
        end
        else if (adx > ady)
        begin
            b_major_x = 1'b1;
            b_cx      = lx;
            b_cy      = ly;
            b_neg     = !(hy > ly);
            b_major   = adx;
            b_minor   = ady;
        end
        else
        begin
            b_major_x = 1'b0;
            if (hy > ly)
            begin
                b_cx  = lx;
                b_cy  = ly;
                b_neg = 1'b0;
            end
            else
            begin
                b_cx  = hx;
                b_cy  = hy;
                b_neg = 1'b1;
            end
            b_major = ady;
            b_minor = adx;
        end
    end

    // At exactly 45 degrees the slope is one whole unit.
    assign b_top = !(x_eq || y_eq) && (b_minor == b_major);

    // Restoring division, one quotient bit a cycle.
    assign rem2    = {rem_reg, 1'b0};
    assign rem_ge  = rem2 >= {1'b0, major_reg};
    assign rem_sub = rem2 - {1'b0, major_reg};

    // Pixel coordinates wrap to the output width.
    assign cx_ext = {{PW{1'b0}}, cur_x_reg};
    assign cy_ext = {{PW{1'b0}}, cur_y_reg};
    assign cx14   = cx_ext[PW-1:0];
    assign cy14   = cy_ext[PW-1:0];
    assign off14  = minor_neg_reg ? {PW{1'b1}} : PW'(1);
    assign nx14   = major_x_reg ? cx14 : (cx14 + off14);
    assign ny14   = major_x_reg ? (cy14 + off14) : cy14;

    assign cov        = err_reg[ERR_W-1:FRAC_BITS];
    assign last_step  = steps_reg <= (CB+1)'(1);
    assign err_diff   = {1'b0, err_reg} - err_step_reg;
    assign err_borrow = {1'b0, err_reg} < err_step_reg;
    assign steps_dec  = (steps_reg != '0) ? (steps_reg - (CB+1)'(1)) : steps_reg;
    assign advance    = (cmd.emit_first && straight_reg) || cmd.emit_main;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        line_active_next = line_active_reg;
        straight_next    = straight_reg;
        major_x_next     = major_x_reg;
        minor_neg_next   = minor_neg_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        steps_next       = steps_reg;
        err_next         = err_reg;
        err_step_next    = err_step_reg;
        major_next       = major_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        px_next          = px_reg;
        py_next          = py_reg;
        inten_next       = inten_reg;
        run_last_next    = run_last_reg;
        line_last_next   = line_last_reg;

        if (cmd.div_step)
        begin
            rem_next      = rem_ge ? rem_sub[CB-1:0] : rem2[CB-1:0];
            err_step_next = {err_step_reg[STEP_W-2:0], rem_ge};
            cnt_next      = cnt_reg - CNT_W'(1);
        end

        if (cmd.load_line)
        begin
            line_active_next = 1'b1;
            straight_next    = x_eq || y_eq;
            major_x_next     = b_major_x;
            minor_neg_next   = b_neg;
            cur_x_next       = b_cx;
            cur_y_next       = b_cy;
            steps_next       = {1'b0, b_major} + (CB+1)'(1);
            err_next         = {8'd255, {FRAC_BITS{1'b0}}};
            err_step_next    = {{(STEP_W-1){1'b0}}, b_top};
            major_next       = b_major;
            rem_next         = b_top ? '0 : b_minor;
            cnt_next         = CNT_W'(DIV_ITERS);
        end

        if (cmd.emit_first)
        begin
            out_valid_next = 1'b1;
            if (straight_reg)
            begin
                px_next        = cx14;
                py_next        = cy14;
                inten_next     = alr_pkg::FULL_INTENSITY;
                run_last_next  = 1'b1;
                line_last_next = last_step;
            end
            else
            begin
                px_next        = nx14;
                py_next        = ny14;
                inten_next     = alr_pkg::FULL_INTENSITY - cov;
                run_last_next  = 1'b0;
                line_last_next = 1'b0;
            end
        end

        if (cmd.emit_main)
        begin
            out_valid_next = 1'b1;
            px_next        = cx14;
            py_next        = cy14;
            inten_next     = cov;
            run_last_next  = 1'b1;
            line_last_next = last_step;
            // A borrow wraps the error back up by 256 whole units.
            err_next       = err_diff[ERR_W-1:0];
        end

        if (advance)
        begin
            if (major_x_reg)
            begin
                cur_x_next = cur_x_reg + CB'(1);
            end
            else
            begin
                cur_y_next = cur_y_reg + CB'(1);
            end
            if (cmd.emit_main && err_borrow)
            begin
                if (major_x_reg)
                begin
                    cur_y_next = minor_neg_reg ? (cur_y_reg - CB'(1)) : (cur_y_reg + CB'(1));
                end
                else
                begin
                    cur_x_next = minor_neg_reg ? (cur_x_reg - CB'(1)) : (cur_x_reg + CB'(1));
                end
            end
            steps_next       = steps_dec;
            line_active_next = steps_dec != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            straight_reg    <= 1'b0;
            major_x_reg     <= 1'b0;
            minor_neg_reg   <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            steps_reg       <= '0;
            err_reg         <= '0;
            err_step_reg    <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            line_active_reg <= line_active_next;
            straight_reg    <= straight_next;
            major_x_reg     <= major_x_next;
            minor_neg_reg   <= minor_neg_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            steps_reg       <= steps_next;
            err_reg         <= err_next;
            err_step_reg    <= err_step_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg     <= major_next;
        rem_reg       <= rem_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        inten_reg     <= inten_next;
        run_last_reg  <= run_last_next;
        line_last_reg <= line_last_next;
    end

    assign stat.line_active    = line_active_reg;
    assign stat.straight_mode  = straight_reg;
    assign stat.begin_straight = x_eq || y_eq;
    assign stat.div_done       = cnt_reg == CNT_W'(1);
    assign stat.out_free       = out_free;

    assign out_valid = out_valid_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign intensity = inten_reg;
    assign run_last  = run_last_reg;
    assign line_last = line_last_reg;

    `ALR_ASSERT(rem_below_divisor, clk, rst_n, !cmd.div_step || (rem_reg < major_reg), "Division remainder not below divisor")
    `ALR_ASSERT(last_pixel_ends_line, clk, rst_n, !(out_valid_reg && line_last_reg) || !line_active_reg, "Final pixel shown while line still active")
    `ALR_ASSERT_NEXT(main_pixel_ends_run, clk, rst_n, cmd.emit_main, out_valid_reg && run_last_reg, "Main pixel not marked as end of step")

endmodule
